// ===== rtl/ldsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ldsc_pkg
// Shared constants, types and the segment font of the matrix and digit scanner.
// ----------------------------------------------------------------------------
package ldsc_pkg;

  localparam int ROWS       = 16;
  localparam int COLUMNS    = 8;
  localparam int SLOT_TICKS = 100;
  localparam int DIGITS     = 3;

  localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_AW  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int TICK_W  = (SLOT_TICKS > 1) ? $clog2(SLOT_TICKS) : 1;
  localparam int DIG_W   = 2;

  localparam int ONT_W   = 7;
  localparam int RIDX_W  = 4;
  localparam int PIX_W   = 8;
  localparam int SCORE_W = 10;
  localparam int RENA_W  = 16;
  localparam int SEG_W   = 7;
  localparam int DSEL_W  = 3;

  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 40;

  localparam logic [ONT_W-1:0] ON_TIME_RESET = 7'd50;

  localparam logic [1:0] MODE_ROW   = 2'd0;
  localparam logic [1:0] MODE_SCORE = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  typedef struct packed {
    logic              en;
    logic [ROW_AW-1:0] addr;
    logic [PIX_W-1:0]  data;
  } ldsc_wr_t;

  typedef struct packed {
    logic              en;
    logic [ROW_AW-1:0] addr;
  } ldsc_rd_t;

  function automatic logic [SEG_W-1:0] seg_font(input logic [3:0] v);
    logic [SEG_W-1:0] s;
    case (v)
      4'd0:    s = 7'h3f;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5b;
      4'd3:    s = 7'h4f;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6d;
      4'd6:    s = 7'h7d;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7f;
      4'd9:    s = 7'h6f;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ldsc_frame_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ldsc_frame_store
// Frame row memory, registered read, per-row valid bits cleared at
// reset, write-to-read forwarding within the same cycle.
// ----------------------------------------------------------------------------
module ldsc_frame_store (
  input  wire                         clk,
  input  wire                         rst,
  input  ldsc_pkg::ldsc_wr_t          wr,
  input  ldsc_pkg::ldsc_rd_t          rd,
  output logic [ldsc_pkg::PIX_W-1:0]  rd_data
);
  import ldsc_pkg::*;

  logic [PIX_W-1:0] mem [ROWS];
  logic [ROWS-1:0]  row_valid;
  logic [PIX_W-1:0] mem_q;
  logic             fwd;
  logic [PIX_W-1:0] fwd_data;
  logic             hit_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      mem_q <= mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr.en) begin
      row_valid[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      fwd       <= wr.en && (wr.addr == rd.addr);
      fwd_data  <= wr.data;
      hit_valid <= row_valid[rd.addr];
    end
  end

  assign rd_data = fwd ? fwd_data : (hit_valid ? mem_q : '0);

endmodule
`default_nettype wire

// ===== rtl/led_matrix_and_digit_scanner.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// led_matrix_and_digit_scanner
// Scan driver for a 16x8 LED matrix and a three-digit seven-segment score.
// ----------------------------------------------------------------------------
// Pipeline: two register stages, stage 1 and the output register.
// Throughput: one item per cycle; the frame store read runs in the same cycle
// as the scan-position update. A held output stalls both stages and the input.
// Reset: frame rows read as zero (valid bits), score 0, scan at first pixel,
// matrix phase, on_time 50. No clearing pass.
module led_matrix_and_digit_scanner (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_tvalid,
  output logic                               s_tready,
  // [3:0] row_index, [11:4] row_bits, [21:12] score, [23:22] zero
  input  wire  [ldsc_pkg::S_TDATA_W-1:0]     s_tdata,
  // [1:0] mode
  input  wire  [1:0]                         s_tuser,
  output logic                               m_tvalid,
  input  wire                                m_tready,
  // [15:0] row_enables, [23:16] column_drive, [26:24] digit_select,
  // [33:27] segments, [39:34] zero
  output logic [ldsc_pkg::M_TDATA_W-1:0]     m_tdata,
  // [0] in_digit_phase
  output logic                               m_tuser,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [ldsc_pkg::ONT_W-1:0]         cfg_data
);
  import ldsc_pkg::*;

  logic [ONT_W-1:0]   on_time;
  logic [SCORE_W-1:0] shown_score;
  logic [TICK_W-1:0]  slot_tick;
  logic [COL_AW-1:0]  scan_column;
  logic [ROW_AW-1:0]  scan_row;
  logic               digit_phase;
  logic [DIG_W-1:0]   scan_digit;

  logic [1:0]         in_mode;
  logic [RIDX_W-1:0]  in_row;
  logic [PIX_W-1:0]   in_bits;
  logic [SCORE_W-1:0] in_score;

  logic               adv;
  logic               accept;
  logic               is_tick;
  logic [SCORE_W-1:0] score_now;
  logic [ONT_W-1:0]   off_len;
  logic               lit;
  logic [RENA_W-1:0]  rows_now;
  logic [DSEL_W-1:0]  dsel_now;
  logic [15:0]        prod100;
  logic [17:0]        prod10;

  ldsc_wr_t           fs_wr;
  ldsc_rd_t           fs_rd;
  logic [PIX_W-1:0]   fs_data;

  // stage 1
  logic               s1_valid;
  logic [RENA_W-1:0]  s1_rows;
  logic               s1_pix;
  logic [COL_AW-1:0]  s1_col;
  logic [DSEL_W-1:0]  s1_dsel;
  logic               s1_seg_on;
  logic [DIG_W-1:0]   s1_digit;
  logic               s1_dph;
  logic [3:0]         s1_q100;
  logic [6:0]         s1_q10;
  logic [SCORE_W-1:0] s1_score;

  // stage 2 (output register)
  logic [RENA_W-1:0]  out_rows;
  logic [PIX_W-1:0]   out_cols;
  logic [DSEL_W-1:0]  out_dsel;
  logic [SEG_W-1:0]   out_segs;
  logic               out_dph;

  logic [PIX_W-1:0]   cols_s1;
  logic [14:0]        tens_prod;
  logic [6:0]         q10_div;
  logic [3:0]         tens_val;
  logic [3:0]         ones_val;
  logic [3:0]         digit_val;
  logic [SEG_W-1:0]   segs_s1;

  logic [TICK_W-1:0]  slot_tick_next;
  logic [COL_AW-1:0]  scan_column_next;
  logic [ROW_AW-1:0]  scan_row_next;
  logic               digit_phase_next;
  logic [DIG_W-1:0]   scan_digit_next;

  assign in_mode  = s_tuser;
  assign in_row   = s_tdata[3:0];
  assign in_bits  = s_tdata[11:4];
  assign in_score = s_tdata[21:12];

  assign adv       = !m_tvalid || m_tready;
  assign s_tready  = adv;
  assign accept    = s_tvalid && adv;
  assign is_tick   = (in_mode == MODE_TICK);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      on_time <= ON_TIME_RESET;
    end else if (cfg_valid) begin
      on_time <= cfg_data;
    end
  end

  // --- frame store access ---
  always_comb begin
    fs_wr.en   = accept && (in_mode == MODE_ROW) && (32'(in_row) < ROWS);
    fs_wr.addr = ROW_AW'(in_row);
    fs_wr.data = in_bits;
    fs_rd.en   = adv;
    fs_rd.addr = scan_row;
  end

  ldsc_frame_store u_frame_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (fs_wr),
    .rd      (fs_rd),
    .rd_data (fs_data)
  );

  // --- current position outputs ---
  always_comb begin
    score_now = (accept && (in_mode == MODE_SCORE)) ? in_score : shown_score;
    off_len   = (32'(on_time) >= SLOT_TICKS) ? '0 : ONT_W'(SLOT_TICKS - 32'(on_time));
    lit       = (ONT_W'(slot_tick) >= off_len);
    rows_now  = '0;
    if (32'(scan_row) < RENA_W) begin
      rows_now = RENA_W'(1) << scan_row;
    end
    dsel_now = '1;
    if (lit) begin
      dsel_now = ~(DSEL_W'(1) << scan_digit);
    end else if (scan_digit != '0) begin
      dsel_now = ~(DSEL_W'(1) << (scan_digit - DIG_W'(1)));
    end
    prod100 = 16'(score_now) * 16'd41;
    prod10  = 18'(score_now) * 18'd205;
  end

  // --- scan position advance ---
  always_comb begin
    slot_tick_next   = slot_tick;
    scan_column_next = scan_column;
    scan_row_next    = scan_row;
    digit_phase_next = digit_phase;
    scan_digit_next  = scan_digit;
    if (32'(slot_tick) != SLOT_TICKS - 1) begin
      slot_tick_next = slot_tick + TICK_W'(1);
    end else begin
      slot_tick_next = '0;
      if (!digit_phase) begin
        if (32'(scan_column) != COLUMNS - 1) begin
          scan_column_next = scan_column + COL_AW'(1);
        end else begin
          scan_column_next = '0;
          if (32'(scan_row) != ROWS - 1) begin
            scan_row_next = scan_row + ROW_AW'(1);
          end else begin
            scan_row_next    = '0;
            digit_phase_next = 1'b1;
            scan_digit_next  = '0;
          end
        end
      end else begin
        if (32'(scan_digit) != DIGITS - 1) begin
          scan_digit_next = scan_digit + DIG_W'(1);
        end else begin
          scan_digit_next  = '0;
          digit_phase_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shown_score <= '0;
      slot_tick   <= '0;
      scan_column <= '0;
      scan_row    <= '0;
      digit_phase <= 1'b0;
      scan_digit  <= '0;
    end else if (accept) begin
      shown_score <= score_now;
      if (is_tick) begin
        slot_tick   <= slot_tick_next;
        scan_column <= scan_column_next;
        scan_row    <= scan_row_next;
        digit_phase <= digit_phase_next;
        scan_digit  <= scan_digit_next;
      end
    end
  end

  // --- stage 1 ---
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_rows   <= digit_phase ? '0 : rows_now;
      s1_pix    <= !digit_phase && lit;
      s1_col    <= scan_column;
      s1_dsel   <= digit_phase ? dsel_now : '1;
      s1_seg_on <= digit_phase && lit;
      s1_digit  <= scan_digit;
      s1_dph    <= digit_phase;
      s1_q100   <= prod100[15:12];
      s1_q10    <= prod10[17:11];
      s1_score  <= score_now;
    end
  end

  // --- stage 1 to output ---
  always_comb begin
    cols_s1 = '1;
    if (s1_pix && fs_data[s1_col]) begin
      cols_s1 = ~(PIX_W'(1) << s1_col);
    end
    tens_prod = 15'(s1_q10) * 15'd205;
    q10_div   = 7'(tens_prod[14:11]);
    tens_val  = 4'(s1_q10 - 7'(q10_div * 7'd10));
    ones_val  = 4'(s1_score - SCORE_W'(10'(s1_q10) * 10'd10));
    case (s1_digit)
      2'd0:    digit_val = s1_q100;
      2'd1:    digit_val = tens_val;
      2'd2:    digit_val = ones_val;
      default: digit_val = 4'hf;
    endcase
    segs_s1 = s1_seg_on ? seg_font(digit_val) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rows <= s1_rows;
      out_cols <= cols_s1;
      out_dsel <= s1_dsel;
      out_segs <= segs_s1;
      out_dph  <= s1_dph;
    end
  end

  assign m_tdata = {6'b0, out_segs, out_dsel, out_cols, out_rows};
  assign m_tuser = out_dph;

  // --- checks ---
  a_digit_cols_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[23:16] == 8'hff) && (m_tdata[15:0] == '0))
    else $error("column lines driven in digit phase");

  a_matrix_digits_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[26:24] == 3'b111) && (m_tdata[33:27] == '0))
    else $error("digits driven in matrix phase");

  a_one_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(m_tdata[15:0]))
    else $error("more than one row enabled");

  a_tick_step: assert property (@(posedge clk) disable iff (rst)
    accept && is_tick && (32'(slot_tick) != SLOT_TICKS - 1)
      |=> slot_tick == $past(slot_tick) + TICK_W'(1))
    else $error("slot tick did not step");

  a_tick_range: assert property (@(posedge clk) disable iff (rst)
    32'(slot_tick) < SLOT_TICKS)
    else $error("slot tick out of range");

endmodule
`default_nettype wire
